// File: hdl/timed_event_queue_unit_macros.svh
// Assertion macros for the timed event queue.
// Included by the top level; depends on nothing.
`ifndef TIMED_EVENT_QUEUE_UNIT_MACROS_SVH
`define TIMED_EVENT_QUEUE_UNIT_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define TEQ_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define TEQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/teq_pkg.sv
// Shared constants, types and helpers for the timed event queue.
// No dependencies.
package teq_pkg;

   localparam int QUEUE_SLOTS = 32;
   localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
   localparam int BEAT_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int EVENT_W     = BEAT_W + 4 * BYTE_W;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic [BEAT_W-1:0] beat;
      logic [BYTE_W-1:0] tick;
      logic [BYTE_W-1:0] command;
      logic [BYTE_W-1:0] data_one;
      logic [BYTE_W-1:0] data_two;
   } event_type;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_ENQ_FREE = 7'b0000010,
      S_ENQ_WALK = 7'b0000100,
      S_ENQ_INS  = 7'b0001000,
      S_ENQ_LINK = 7'b0010000,
      S_DEQ_READ = 7'b0100000,
      S_DONE     = 7'b1000000
   } state_type;

   // Link value of a slot in a freshly built free chain.
   function automatic slot_type free_link(input slot_type s);
      logic [SLOT_W:0] nxt;
      nxt = {1'b0, s} + 1'b1;
      if (nxt < (SLOT_W+1)'(QUEUE_SLOTS)) begin
         return nxt[SLOT_W-1:0];
      end
      return '0;
   endfunction

   // Time a is at or after time b.
   function automatic logic time_ge(input logic [BEAT_W-1:0] a_beat,
                                    input logic [BYTE_W-1:0] a_tick,
                                    input logic [BEAT_W-1:0] b_beat,
                                    input logic [BYTE_W-1:0] b_tick);
      return {a_beat, a_tick} >= {b_beat, b_tick};
   endfunction

endpackage

// File: hdl/timed_event_queue_unit.sv
// Timed event queue: time-sorted linked list of MIDI events in two RAMs.
// Depends on teq_pkg, teq_ram and timed_event_queue_unit_macros.svh.
//
// Events are kept as a singly linked list sorted by {beat, tick} in an event
// RAM (48-bit words) and a link RAM (slot numbers), both with a registered
// read. Slot 0 is the null link; free slots sit on a LIFO free list.
// One request word is taken at a time and gives exactly one response word.
// Enqueue inserts ahead of the first event at an equal or later time (newest
// first among ties); ok is low when no slot is free. Dequeue returns the head
// event if the given time has reached it, otherwise ok low and zero fields.
// Clear rebuilds the free list and empties the queue: the link RAM has a
// valid bit per slot, and a slot without one reads as its free-chain default,
// so there is no clearing pass after reset either.
// Clear, an undefined op, an enqueue into a full queue and a dequeue from an
// empty one go straight to the response; a dequeue reads the head first; an
// enqueue pops the free list, walks the queue one link per cycle (at most
// QUEUE_SLOTS-2 queued events), writes the new link, and writes the
// predecessor's link as well when the new event does not become the head.
// A new request is taken the cycle after the response is loaded; the response
// register holds its word under stall while the next request is already in
// progress.
`include "timed_event_queue_unit_macros.svh"

module timed_event_queue_unit (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_operation,
   input  logic [teq_pkg::BEAT_W-1:0] req_beat,
   input  logic [teq_pkg::BYTE_W-1:0] req_tick,
   input  logic [teq_pkg::BYTE_W-1:0] req_command,
   input  logic [teq_pkg::BYTE_W-1:0] req_data_one,
   input  logic [teq_pkg::BYTE_W-1:0] req_data_two,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_ok,
   output logic [teq_pkg::BEAT_W-1:0] rsp_out_beat,
   output logic [teq_pkg::BYTE_W-1:0] rsp_out_tick,
   output logic [teq_pkg::BYTE_W-1:0] rsp_out_command,
   output logic [teq_pkg::BYTE_W-1:0] rsp_out_data_one,
   output logic [teq_pkg::BYTE_W-1:0] rsp_out_data_two
);

   import teq_pkg::*;

   // Sequencer and list pointers
   state_type state_ff, state_in;
   slot_type  queue_head_ff, queue_head_in;
   slot_type  free_head_ff, free_head_in;
   slot_type  slot_ff, slot_in;          // slot taken by the current enqueue
   slot_type  prev_ff, prev_in;          // walk: last event earlier than new one
   slot_type  ptr_ff, ptr_in;            // walk: event under test
   event_type ev_ff, ev_in;              // request word held for the walk

   // Pending result and the response register
   logic      res_ok_ff, res_ok_in;
   event_type res_ev_ff, res_ev_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_ok_ff, rsp_ok_in;
   event_type rsp_ev_ff, rsp_ev_in;

   // Event RAM ports
   logic      evt_wr_en;
   slot_type  evt_wr_addr;
   event_type evt_wr_data;
   slot_type  evt_rd_addr;
   logic [EVENT_W-1:0] evt_rd_data;
   event_type rd_ev;

   // Link RAM ports; per-slot valid bits stand in for the free-chain reset
   logic      lnk_wr_en;
   slot_type  lnk_wr_addr;
   slot_type  lnk_wr_data;
   slot_type  lnk_rd_addr;
   slot_type  lnk_rd_data;
   logic      lnk_clear;
   logic [QUEUE_SLOTS-1:0] lnk_valid_ff, lnk_valid_in;
   logic      lnk_dflt_ff;               // read slot had no valid bit
   slot_type  lnk_dflt_val_ff;           // its free-chain default
   slot_type  lnk_rd_val;

   logic      req_accept;
   logic      rsp_free;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rd_ev      = event_type'(evt_rd_data);
   assign lnk_rd_val = lnk_dflt_ff ? lnk_dflt_val_ff : lnk_rd_data;

   teq_ram #(.WIDTH(EVENT_W), .DEPTH(QUEUE_SLOTS)) u_event_ram (
      .clock   (clock),
      .wr_en   (evt_wr_en),
      .wr_addr (evt_wr_addr),
      .wr_data (evt_wr_data),
      .rd_addr (evt_rd_addr),
      .rd_data (evt_rd_data)
   );

   teq_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (lnk_wr_en),
      .wr_addr (lnk_wr_addr),
      .wr_data (lnk_wr_data),
      .rd_addr (lnk_rd_addr),
      .rd_data (lnk_rd_data)
   );

   // Sequencer: one request at a time, one link visited per cycle
   always_comb begin
      state_in      = state_ff;
      queue_head_in = queue_head_ff;
      free_head_in  = free_head_ff;
      slot_in       = slot_ff;
      prev_in       = prev_ff;
      ptr_in        = ptr_ff;
      ev_in         = ev_ff;
      res_ok_in     = res_ok_ff;
      res_ev_in     = res_ev_ff;

      evt_wr_en     = 1'b0;
      evt_wr_addr   = free_head_ff;
      evt_wr_data   = ev_ff;
      evt_rd_addr   = ptr_ff;
      lnk_wr_en     = 1'b0;
      lnk_wr_addr   = slot_ff;
      lnk_wr_data   = ptr_ff;
      lnk_rd_addr   = ptr_ff;
      lnk_clear     = 1'b0;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_ok_in     = rsp_ok_ff;
      rsp_ev_in     = rsp_ev_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               ev_in     = '{beat: req_beat, tick: req_tick, command: req_command,
                             data_one: req_data_one, data_two: req_data_two};
               res_ev_in = '0;
               res_ok_in = 1'b0;
               state_in  = S_DONE;
               case (op_type'(req_operation))
                  OP_ENQUEUE: begin
                     if (free_head_ff != '0) begin
                        // store the event in the free slot, fetch its link
                        evt_wr_en   = 1'b1;
                        evt_wr_addr = free_head_ff;
                        evt_wr_data = ev_in;
                        slot_in     = free_head_ff;
                        lnk_rd_addr = free_head_ff;
                        state_in    = S_ENQ_FREE;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (queue_head_ff != '0) begin
                        evt_rd_addr = queue_head_ff;
                        lnk_rd_addr = queue_head_ff;
                        state_in    = S_DEQ_READ;
                     end
                  end
                  OP_CLEAR: begin
                     lnk_clear     = 1'b1;
                     free_head_in  = slot_type'(1);
                     queue_head_in = '0;
                     res_ok_in     = 1'b1;
                  end
                  default: begin
                     res_ok_in = 1'b0;
                  end
               endcase
            end
         end

         S_ENQ_FREE: begin
            // pop the free list, then start at the queue head
            free_head_in = lnk_rd_val;
            prev_in      = '0;
            ptr_in       = queue_head_ff;
            if (queue_head_ff == '0) begin
               state_in = S_ENQ_INS;
            end else begin
               evt_rd_addr = queue_head_ff;
               lnk_rd_addr = queue_head_ff;
               state_in    = S_ENQ_WALK;
            end
         end

         S_ENQ_WALK: begin
            if (time_ge(rd_ev.beat, rd_ev.tick, ev_ff.beat, ev_ff.tick)) begin
               state_in = S_ENQ_INS;
            end else begin
               prev_in = ptr_ff;
               ptr_in  = lnk_rd_val;
               if (lnk_rd_val == '0) begin
                  state_in = S_ENQ_INS;
               end else begin
                  evt_rd_addr = lnk_rd_val;
                  lnk_rd_addr = lnk_rd_val;
               end
            end
         end

         S_ENQ_INS: begin
            lnk_wr_en   = 1'b1;
            lnk_wr_addr = slot_ff;
            lnk_wr_data = ptr_ff;
            if (prev_ff == '0) begin
               queue_head_in = slot_ff;
               res_ok_in     = 1'b1;
               state_in      = S_DONE;
            end else begin
               state_in = S_ENQ_LINK;
            end
         end

         S_ENQ_LINK: begin
            lnk_wr_en   = 1'b1;
            lnk_wr_addr = prev_ff;
            lnk_wr_data = slot_ff;
            res_ok_in   = 1'b1;
            state_in    = S_DONE;
         end

         S_DEQ_READ: begin
            if (time_ge(ev_ff.beat, ev_ff.tick, rd_ev.beat, rd_ev.tick)) begin
               res_ok_in     = 1'b1;
               res_ev_in     = rd_ev;
               queue_head_in = lnk_rd_val;
               // push the head slot onto the free list
               lnk_wr_en     = 1'b1;
               lnk_wr_addr   = queue_head_ff;
               lnk_wr_data   = free_head_ff;
               free_head_in  = queue_head_ff;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_ev_in    = res_ev_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Link valid bits: cleared together, set by each write
   always_comb begin
      lnk_valid_in = lnk_valid_ff;
      if (lnk_clear) begin
         lnk_valid_in = '0;
      end else if (lnk_wr_en) begin
         lnk_valid_in[lnk_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         queue_head_ff <= '0;
         free_head_ff  <= slot_type'(1);
         lnk_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         queue_head_ff <= queue_head_in;
         free_head_ff  <= free_head_in;
         lnk_valid_ff  <= lnk_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff         <= slot_in;
      prev_ff         <= prev_in;
      ptr_ff          <= ptr_in;
      ev_ff           <= ev_in;
      res_ok_ff       <= res_ok_in;
      res_ev_ff       <= res_ev_in;
      rsp_ok_ff       <= rsp_ok_in;
      rsp_ev_ff       <= rsp_ev_in;
      lnk_dflt_ff     <= !lnk_valid_ff[lnk_rd_addr];
      lnk_dflt_val_ff <= free_link(lnk_rd_addr);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_out_beat     = rsp_ev_ff.beat;
   assign rsp_out_tick     = rsp_ev_ff.tick;
   assign rsp_out_command  = rsp_ev_ff.command;
   assign rsp_out_data_one = rsp_ev_ff.data_one;
   assign rsp_out_data_two = rsp_ev_ff.data_two;

   // Checks

   // a response without ok carries no event
   `TEQ_ASSERT_IMPLY(a_nok_zero, clock, reset, rsp_valid_ff && !rsp_ok_ff, rsp_ev_ff == '0, "response without ok carries event data")

   // queue and free list never share their first slot
   `TEQ_ASSERT_IMPLY(a_lists_apart, clock, reset, queue_head_ff != '0, queue_head_ff != free_head_ff, "queue head is also on the free list")

   // the walk only visits queued slots, never the one being inserted
   `TEQ_ASSERT_IMPLY(a_walk_ptr, clock, reset, state_ff == S_ENQ_WALK, (ptr_ff != '0) && (ptr_ff != slot_ff), "walk pointer is null or the new slot")

endmodule

// File: hdl/teq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module teq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
